>>> sv/rqjs_pkg.sv
`timescale 1ns / 1ps

package rqjs_pkg;

  localparam int TASKS     = 16;
  localparam int TIME_BITS = 16;
  localparam int ID_BITS   = 4;
  localparam int OP_BITS   = 2;
  localparam int POL_BITS  = 2;
  localparam int CNT_BITS  = $clog2(TASKS + 1);
  localparam int STEP_BITS = $clog2(TASKS);

  // APB register map: one 32-bit register per word
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;
  localparam int REG_POLICY = 0;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SELECT = 2'd2,
    OP_CHARGE = 2'd3
  } op_e;

  typedef enum logic [POL_BITS-1:0] {
    POL_FIFO     = 2'd0,
    POL_SHORTEST = 2'd1,
    POL_RR       = 2'd2
  } pol_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] time_left;
  } entry_t;

  typedef struct packed {
    logic [OP_BITS-1:0]   opcode;
    logic [ID_BITS-1:0]   task_id;
    logic [TIME_BITS-1:0] burst_time;
    logic [TIME_BITS-1:0] runtime;
  } in_req_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  selected_id;
    logic                found;
    logic [CNT_BITS-1:0] entries;
  } out_req_t;

  // sequencer to cell row
  typedef struct packed {
    logic   shift;
    entry_t feed;
  } chain_ctl_t;

endpackage

>>> sv/rqjs_cell.sv
`timescale 1ns / 1ps

module rqjs_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  rqjs_pkg::entry_t nxt_i,
  output rqjs_pkg::entry_t ent_o
);
  import rqjs_pkg::*;

  entry_t ent_q;

  // take the neighbour's entry on every shift step, hold otherwise
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= nxt_i;
    end
  end

  assign ent_o = ent_q;

endmodule

>>> sv/rqjs_ctrl.sv
`timescale 1ns / 1ps

module rqjs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rqjs_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rqjs_pkg::out_req_t            out_req_o,
  input  logic [rqjs_pkg::POL_BITS-1:0] policy_i,
  input  rqjs_pkg::entry_t              head_i,
  input  rqjs_pkg::entry_t              second_i,
  output rqjs_pkg::chain_ctl_t          ctl_o
);
  import rqjs_pkg::*;

  state_e               state_q, state_d;
  logic [STEP_BITS-1:0] step_q;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 fresh_q, fresh_d;
  logic                 out_valid_q;
  logic                 hit_q, hit_d;
  logic                 drop_q;
  logic                 pass2_q;

  logic [OP_BITS-1:0]   op_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TIME_BITS-1:0] etime_q;
  logic [TIME_BITS-1:0] rtime_q;
  logic [POL_BITS-1:0]  pol_q;
  entry_t               hold_q;
  logic [TIME_BITS-1:0] best_time_q;
  logic [ID_BITS-1:0]   best_id_q;
  out_req_t             out_q;
  out_req_t             res;

  logic                 accept;
  logic                 out_free;
  logic                 start_scan;
  logic                 start_hit;
  logic [CNT_BITS-1:0]  s_ext;
  logic                 in_range;
  logic                 last_step;
  logic                 id_match;
  logic                 charge_hit;
  logic                 need_head;
  logic                 best_upd;
  logic [TIME_BITS-1:0] sat;
  entry_t               feed;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign s_ext     = CNT_BITS'(step_q);
  assign in_range  = s_ext < cnt_q;
  assign last_step = step_q == STEP_BITS'(TASKS - 1);

  // first hit behind the head; the head itself is tried on a second pass
  assign id_match = in_range && (step_q != '0) && (head_i.id == id_q) && !hit_q && !pass2_q;
  assign sat      = (head_i.time_left > rtime_q) ? head_i.time_left - rtime_q : '0;
  assign best_upd = in_range && ((step_q == '0) || (head_i.time_left < best_time_q));
  assign hit_d    = hit_q || id_match;
  assign need_head = ((op_q == OP_REMOVE) || (op_q == OP_CHARGE)) && !pass2_q && !hit_d &&
                     (cnt_q != '0) && (hold_q.id == id_q);

  always_comb begin
    start_scan = 1'b0;
    start_hit  = 1'b0;
    case (in_req_i.opcode)
      OP_INSERT: begin
        start_hit  = cnt_q < CNT_BITS'(TASKS);
        start_scan = start_hit;
      end
      OP_SELECT: begin
        start_hit  = cnt_q != '0;
        start_scan = start_hit && ((policy_i == POL_SHORTEST) ||
                     ((policy_i == POL_RR) && !fresh_q && (cnt_q > CNT_BITS'(1))));
      end
      default: begin
        start_scan = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = start_scan ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (last_step && !need_head) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // feed into the tail cell, result and state updates
  always_comb begin
    charge_hit = pass2_q ? (step_q == '0) : id_match;
    case (op_q)
      OP_INSERT: feed = (s_ext == cnt_q) ? entry_t'{id: id_q, time_left: etime_q} : head_i;
      OP_REMOVE: feed = (pass2_q || drop_q || id_match) ? second_i : head_i;
      OP_CHARGE: feed = charge_hit ? entry_t'{id: head_i.id, time_left: sat} : head_i;
      OP_SELECT: begin
        if (pol_q == POL_RR) begin
          feed = (s_ext == cnt_q - CNT_BITS'(1)) ? hold_q : second_i;
        end else begin
          feed = head_i;
        end
      end
      default: feed = head_i;
    endcase

    cnt_d   = cnt_q;
    fresh_d = fresh_q;
    case (op_q)
      OP_INSERT: begin
        if (hit_q) begin
          cnt_d = cnt_q + CNT_BITS'(1);
        end
      end
      OP_REMOVE: begin
        if (hit_q) begin
          cnt_d = cnt_q - CNT_BITS'(1);
          if (cnt_q == CNT_BITS'(1)) begin
            fresh_d = 1'b1;
          end
        end
      end
      OP_SELECT: begin
        if (cnt_q == '0) begin
          fresh_d = 1'b1;
        end else if (pol_q == POL_RR) begin
          fresh_d = 1'b0;
        end
      end
      default: ;
    endcase

    res.selected_id = '0;
    if ((op_q == OP_SELECT) && (cnt_q != '0)) begin
      res.selected_id = (pol_q == POL_SHORTEST) ? best_id_q : head_i.id;
    end
    res.found   = hit_q;
    res.entries = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      drop_q      <= 1'b0;
      pass2_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q  <= '0;
        hit_q   <= start_hit;
        drop_q  <= 1'b0;
        pass2_q <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        step_q <= last_step ? '0 : step_q + STEP_BITS'(1);
        hit_q  <= hit_d || (last_step && need_head);
        drop_q <= drop_q || id_match;
        if (last_step && need_head) begin
          pass2_q <= 1'b1;
        end
      end
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
        fresh_q     <= fresh_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_req_i.opcode;
      id_q    <= in_req_i.task_id;
      etime_q <= in_req_i.burst_time;
      rtime_q <= in_req_i.runtime;
      pol_q   <= policy_i;
      hold_q  <= head_i;
    end
    if ((state_q == ST_SCAN) && best_upd) begin
      best_time_q <= head_i.time_left;
      best_id_q   <= head_i.id;
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign ctl_o       = '{shift: (state_q == ST_SCAN), feed: feed};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("sequencer idle after taking a request");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(TASKS))
    else $error("occupancy above queue depth");

  a_cnt_only_at_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FIN) |=> $stable(cnt_q))
    else $error("occupancy changed outside result load");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |-> (step_q == '0))
    else $error("step counter not parked outside a pass");

  a_pass2_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass2_q |-> ((op_q == OP_REMOVE) || (op_q == OP_CHARGE)))
    else $error("head pass for an op without id lookup");

endmodule

>>> sv/ready_queue_job_selector_top.sv
`timescale 1ns / 1ps
// Passes: a request that runs a pass of the cell row (insert, remove, charge, shortest or
//   rotating round-robin select) gives its result when the pass ends, after a second pass
//   for a remove or charge on the head; other selects and a full insert run no pass.
// Requests: one in work at a time; the next is accepted in the cycle after the result loads,
//   or later while the result side stalls.
// Reset: asynchronous, active low; clears occupancy, sets the round-robin fresh flag, policy fifo.
module ready_queue_job_selector_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rqjs_pkg::in_req_t               in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rqjs_pkg::out_req_t              out_req_o,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [rqjs_pkg::ADDR_BITS-1:0]  paddr_i,
  input  logic [rqjs_pkg::DATA_BITS-1:0]  pwdata_i,
  output logic [rqjs_pkg::DATA_BITS-1:0]  prdata_o,
  output logic                            pready_o
);
  import rqjs_pkg::*;

  // The queue lives in a row of TASKS cells, head in cell 0, tail side at cell TASKS-1.
  // A pass shifts every cell one place towards the head per cycle; what leaves cell 0
  // re-enters at the far end through the sequencer's feed. Choosing the feed (the old head
  // entry, the entry behind it, a new entry or an updated time) lets one pass insert, close
  // up a gap, rotate or charge, while the row returns to its alignment.

  logic [POL_BITS-1:0] policy_q;
  logic                reg_sel;
  logic                reg_wr;
  chain_ctl_t          ctl;
  entry_t              ent [TASKS];
  entry_t              nxt [TASKS];

  // APB register file: policy only, word-aligned; zero-wait, so pready is tied high
  assign reg_sel  = paddr_i[ADDR_BITS-1:2] == (ADDR_BITS-2)'(REG_POLICY);
  assign reg_wr   = psel_i && penable_i && pwrite_i && reg_sel;
  assign pready_o = 1'b1;
  assign prdata_o = reg_sel ? DATA_BITS'(policy_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIFO;
    end else if (reg_wr) begin
      policy_q <= pwdata_i[POL_BITS-1:0];
    end
  end

  // Sequencer: accepts a request, runs a pass if it needs one, then holds the result until taken
  rqjs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .policy_i    (policy_q),
    .head_i      (ent[0]),
    .second_i    (ent[1]),
    .ctl_o       (ctl)
  );

  // Cell row: each cell takes its neighbour nearer the tail; the last takes the feed
  for (genvar k = 0; k < TASKS; k++) begin : g_cell
    if (k == TASKS - 1) begin : g_last
      assign nxt[k] = ctl.feed;
    end else begin : g_mid
      assign nxt[k] = ent[k+1];
    end

    rqjs_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctl.shift),
      .nxt_i   (nxt[k]),
      .ent_o   (ent[k])
    );
  end

endmodule

>>> verif/ready_queue_job_selector_top_tb.sv
`timescale 1ns / 1ps

module ready_queue_job_selector_top_tb;
  import rqjs_pkg::*;

  // Policy value left unused by the register map; the block treats it as fifo.
  localparam logic [POL_BITS-1:0] POL_SPARE = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 200;
  localparam int SETTLE_CYCLES  = 2 * TASKS + 4;

  // Per idling mode: sender gap and receiver stall, in percent.
  localparam int GAP_PCT   [4] = '{0, 56, 0, 29};
  localparam int STALL_PCT [4] = '{0, 0, 56, 29};
  // Occupancy the random requests steer towards; full twice as often, to hit inserts on a full queue.
  localparam int GOALS     [5] = '{0, 3, 8, TASKS, TASKS};
  localparam logic [POL_BITS-1:0] PHASE_POL [8] = '{
    POL_FIFO, POL_SHORTEST, POL_RR, POL_SPARE, POL_RR, POL_SHORTEST, POL_FIFO, POL_RR
  };

  // One row of the directed sequence. Rows with 'typed' set carry their result by hand;
  // the rest are checked against the shadow scheduler.
  typedef struct packed {
    logic [POL_BITS-1:0]  pol;
    logic [OP_BITS-1:0]   op;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] etime;
    logic [TIME_BITS-1:0] rtime;
    logic                 typed;
    out_req_t             want;
  } drill_row_t;

  localparam int DRILL_ROWS = 25;
  localparam drill_row_t DRILL [DRILL_ROWS] = '{
    // empty queue: select, remove and charge all miss
    '{POL_FIFO,     OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b1, '{4'd0, 1'b0, 5'd0}},
    '{POL_FIFO,     OP_REMOVE, 4'd5,  16'd0,      16'd0,      1'b1, '{4'd0, 1'b0, 5'd0}},
    '{POL_FIFO,     OP_CHARGE, 4'd3,  16'd0,      16'hffff,   1'b1, '{4'd0, 1'b0, 5'd0}},
    // fill with extreme ids and times, plus a duplicate id
    '{POL_FIFO,     OP_INSERT, 4'd0,  16'hffff,   16'd0,      1'b1, '{4'd0, 1'b1, 5'd1}},
    '{POL_FIFO,     OP_INSERT, 4'd15, 16'd0,      16'd0,      1'b1, '{4'd0, 1'b1, 5'd2}},
    '{POL_FIFO,     OP_INSERT, 4'd7,  16'd100,    16'd0,      1'b1, '{4'd0, 1'b1, 5'd3}},
    '{POL_FIFO,     OP_INSERT, 4'd7,  16'd50,     16'd0,      1'b1, '{4'd0, 1'b1, 5'd4}},
    '{POL_FIFO,     OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b1, '{4'd0, 1'b1, 5'd4}},
    // charge hits the first duplicate behind the head without saturating
    '{POL_FIFO,     OP_CHARGE, 4'd7,  16'd0,      16'd30,     1'b0, '{4'd0, 1'b0, 5'd0}},
    // charge on the head saturates at zero
    '{POL_FIFO,     OP_CHARGE, 4'd0,  16'd0,      16'hffff,   1'b1, '{4'd0, 1'b1, 5'd4}},
    // absent id leaves the queue alone
    '{POL_FIFO,     OP_REMOVE, 4'd9,  16'd0,      16'd0,      1'b1, '{4'd0, 1'b0, 5'd4}},
    // shortest with a tie at zero, then remove the head
    '{POL_SHORTEST, OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    '{POL_SHORTEST, OP_REMOVE, 4'd0,  16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    '{POL_SHORTEST, OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    // round robin: first select after reset does not rotate, the later ones do
    '{POL_RR,       OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    '{POL_RR,       OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    '{POL_RR,       OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    // spare policy value behaves as fifo
    '{POL_SPARE,    OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    '{POL_SPARE,    OP_CHARGE, 4'd7,  16'd0,      16'd1000,   1'b0, '{4'd0, 1'b0, 5'd0}},
    // drain to empty, which re-arms the round-robin first select
    '{POL_SPARE,    OP_REMOVE, 4'd15, 16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    '{POL_SPARE,    OP_REMOVE, 4'd7,  16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    '{POL_SPARE,    OP_REMOVE, 4'd7,  16'd0,      16'd0,      1'b1, '{4'd0, 1'b1, 5'd0}},
    '{POL_RR,       OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b1, '{4'd0, 1'b0, 5'd0}},
    '{POL_RR,       OP_INSERT, 4'd2,  16'd77,     16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}},
    '{POL_RR,       OP_SELECT, 4'd0,  16'd0,      16'd0,      1'b0, '{4'd0, 1'b0, 5'd0}}
  };

  // Block inputs, all at known values from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  in_req_t              in_req_i    = '0;
  logic                 out_stall_i = 1'b0;
  logic                 psel_i      = 1'b0;
  logic                 penable_i   = 1'b0;
  logic                 pwrite_i    = 1'b0;
  logic [ADDR_BITS-1:0] paddr_i     = '0;
  logic [DATA_BITS-1:0] pwdata_i    = '0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  out_req_t             out_req_o;
  logic [DATA_BITS-1:0] prdata_o;
  logic                 pready_o;

  // Shadow scheduler: ring held from head (index 0) to tail.
  logic [ID_BITS-1:0]   ring_tid  [TASKS];
  logic [TIME_BITS-1:0] ring_left [TASKS];
  int                   ring_fill   = 0;
  bit                   rotate_hold = 1'b1;
  logic [POL_BITS-1:0]  cur_policy  = POL_FIFO;

  out_req_t pending_outcomes [$];
  int       fault_count = 0;
  int       gap_pct     = 0;
  int       stall_pct   = 0;
  bit       hold_go     = 1'b0;
  int       hold_left   = 0;

  ready_queue_job_selector_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .psel_i      (psel_i),
    .penable_i   (penable_i),
    .pwrite_i    (pwrite_i),
    .paddr_i     (paddr_i),
    .pwdata_i    (pwdata_i),
    .prdata_o    (prdata_o),
    .pready_o    (pready_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Position of an id: entries behind the head first, the head last; -1 when absent.
  function automatic int locate_task(logic [ID_BITS-1:0] id);
    int k;
    if (ring_fill == 0) return -1;
    for (k = 1; k < ring_fill; k++) begin
      if (ring_tid[k] == id) return k;
    end
    if (ring_tid[0] == id) return 0;
    return -1;
  endfunction

  // Advance the shadow scheduler by one request and return the result it should produce.
  function automatic out_req_t next_outcome(in_req_t r);
    out_req_t             res;
    int                   pos;
    int                   best;
    int                   k;
    logic [ID_BITS-1:0]   id0;
    logic [TIME_BITS-1:0] t0;
    res = '0;
    case (r.opcode)
      OP_INSERT: begin
        // a full queue drops the insert
        if (ring_fill < TASKS) begin
          ring_tid[ring_fill]  = r.task_id;
          ring_left[ring_fill] = r.burst_time;
          ring_fill++;
          res.found = 1'b1;
        end
      end
      OP_REMOVE: begin
        pos = locate_task(r.task_id);
        if (pos >= 0) begin
          // close up behind the removed entry
          for (k = pos; k < ring_fill - 1; k++) begin
            ring_tid[k]  = ring_tid[k + 1];
            ring_left[k] = ring_left[k + 1];
          end
          ring_fill--;
          if (ring_fill == 0) rotate_hold = 1'b1;
          res.found = 1'b1;
        end
      end
      OP_SELECT: begin
        if (ring_fill == 0) begin
          rotate_hold = 1'b1;
        end else if (cur_policy == POL_SHORTEST) begin
          // strict less-than keeps the entry nearest the head on a tie
          best = 0;
          for (k = 1; k < ring_fill; k++) begin
            if (ring_left[k] < ring_left[best]) best = k;
          end
          res.selected_id = ring_tid[best];
          res.found       = 1'b1;
        end else if (cur_policy == POL_RR) begin
          if (!rotate_hold && ring_fill > 1) begin
            id0 = ring_tid[0];
            t0  = ring_left[0];
            for (k = 0; k < ring_fill - 1; k++) begin
              ring_tid[k]  = ring_tid[k + 1];
              ring_left[k] = ring_left[k + 1];
            end
            ring_tid[ring_fill - 1]  = id0;
            ring_left[ring_fill - 1] = t0;
          end
          rotate_hold     = 1'b0;
          res.selected_id = ring_tid[0];
          res.found       = 1'b1;
        end else begin
          res.selected_id = ring_tid[0];
          res.found       = 1'b1;
        end
      end
      OP_CHARGE: begin
        pos = locate_task(r.task_id);
        if (pos >= 0) begin
          if (ring_left[pos] > r.runtime) ring_left[pos] = ring_left[pos] - r.runtime;
          else ring_left[pos] = '0;
          res.found = 1'b1;
        end
      end
      default: ;
    endcase
    res.entries = CNT_BITS'(ring_fill);
    return res;
  endfunction

  // Random request steered towards an occupancy goal. Remove and charge mostly name an id
  // that is queued; small ids and small times make duplicates and shortest-time ties common.
  function automatic in_req_t random_request(int goal);
    in_req_t r;
    int      roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.opcode = OP_BITS'($urandom_range(0, 3));
    end else if (ring_fill < goal) begin
      r.opcode = (roll < 55) ? OP_INSERT : (roll < 78) ? OP_SELECT :
                 (roll < 90) ? OP_CHARGE : OP_REMOVE;
    end else if (ring_fill > goal) begin
      r.opcode = (roll < 50) ? OP_REMOVE : (roll < 75) ? OP_SELECT :
                 (roll < 90) ? OP_CHARGE : OP_INSERT;
    end else begin
      r.opcode = (roll < 40) ? OP_SELECT : (roll < 60) ? OP_CHARGE :
                 (roll < 80) ? OP_INSERT : OP_REMOVE;
    end

    if ((r.opcode == OP_REMOVE || r.opcode == OP_CHARGE) && ring_fill != 0 &&
        $urandom_range(0, 99) < 85) begin
      r.task_id = ring_tid[$urandom_range(0, ring_fill - 1)];
    end else if ($urandom_range(0, 99) < 40) begin
      r.task_id = ID_BITS'($urandom_range(0, 3));
    end else begin
      r.task_id = ID_BITS'($urandom_range(0, TASKS - 1));
    end

    roll = $urandom_range(0, 99);
    if (roll < 30) r.burst_time = TIME_BITS'($urandom_range(0, 15));
    else if (roll < 35) r.burst_time = '0;
    else if (roll < 40) r.burst_time = '1;
    else r.burst_time = TIME_BITS'($urandom);

    roll = $urandom_range(0, 99);
    if (roll < 40) r.runtime = TIME_BITS'($urandom_range(0, 20));
    else if (roll < 50) r.runtime = '1;
    else r.runtime = TIME_BITS'($urandom);
    return r;
  endfunction

  task automatic log_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("%s", what);
  endtask

  // Offer one request, idling first at random, and hold it until accepted. This task lowers valid
  // only inside the gap loop, so back-to-back requests keep it high without a glitch.
  task automatic send_request(in_req_t r, bit typed, out_req_t want);
    out_req_t res;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = next_outcome(r);
    if (typed) res = want;
    pending_outcomes.push_back(res);
  endtask

  // Change the policy only once every outstanding result has come back, so the block is idle.
  task automatic write_policy(logic [POL_BITS-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= ADDR_BITS'(REG_POLICY * 4);
    pwdata_i  <= DATA_BITS'(value);
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i     <= 1'b0;
    penable_i  <= 1'b0;
    pwrite_i   <= 1'b0;
    cur_policy = value;
  endtask

  // Result side: check each accepted result against the oldest expectation, then decide the
  // stall for the next cycle. A long hold-off, once requested, is counted down here.
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        log_fault($sformatf("unexpected result: id %0d found %0b entries %0d",
                            out_req_o.selected_id, out_req_o.found, out_req_o.entries));
      end else begin
        want = pending_outcomes.pop_front();
        if (out_req_o !== want) begin
          log_fault($sformatf(
            "mismatch: want id %0d found %0b entries %0d, got id %0d found %0b entries %0d",
            want.selected_id, want.found, want.entries,
            out_req_o.selected_id, out_req_o.found, out_req_o.entries));
        end
      end
    end
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: end the run when no request moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("ready_queue_job_selector_top_tb: errors");
    $finish;
  end

  initial begin
    in_req_t r;
    int      n;
    int      p;
    int      goal;
    goal = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequence, no idling; write the policy whenever a row asks for another one.
    for (n = 0; n < DRILL_ROWS; n++) begin
      if (DRILL[n].pol != cur_policy) write_policy(DRILL[n].pol);
      r.opcode     = DRILL[n].op;
      r.task_id    = DRILL[n].id;
      r.burst_time = DRILL[n].etime;
      r.runtime    = DRILL[n].rtime;
      send_request(r, DRILL[n].typed, DRILL[n].want);
    end

    // Random phases: each sets a policy and an idling mode. At the start of one phase with
    // an eager sender, hold the result side off so the block backs up and stalls its input.
    for (p = 0; p < 8; p++) begin
      write_policy(PHASE_POL[p]);
      gap_pct   = GAP_PCT[p % 4];
      stall_pct = STALL_PCT[p % 4];
      if (p == 4) hold_go = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) goal = GOALS[$urandom_range(0, 4)];
        r = random_request(goal);
        send_request(r, 1'b0, '0);
      end
    end

    // Drain, then give stray results time to show up.
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("ready_queue_job_selector_top_tb: clean");
    end else begin
      $display("ready_queue_job_selector_top_tb: errors");
    end
    $finish;
  end

endmodule

>>> ready_queue_job_selector_top.f
sv/rqjs_pkg.sv
sv/rqjs_cell.sv
sv/rqjs_ctrl.sv
sv/ready_queue_job_selector_top.sv
verif/ready_queue_job_selector_top_tb.sv
